// ----- hdl/mfmsd_pkg.sv -----
package mfmsd_pkg;

    // sector layout, in raw longwords counted from the word after sync
    localparam int SECTOR_WORDS = 272;
    localparam int DATA_WORDS   = 128;

    localparam int CNT_W  = $clog2(SECTOR_WORDS + 1);
    localparam int ADDR_W = $clog2(DATA_WORDS);
    localparam int HALF_W = 16;

    localparam logic [31:0] MFM_MASK = 32'h5555_5555;

    localparam int POS_INFO_ODD  = 1;
    localparam int POS_INFO_EVEN = 2;
    localparam int POS_HDR_LAST  = 10;
    localparam int POS_HCK_ODD   = 11;
    localparam int POS_HCK_EVEN  = 12;
    localparam int POS_DCK_ODD   = 13;
    localparam int POS_DCK_EVEN  = 14;
    localparam int POS_DATA      = 15;
    localparam int POS_DATA_END  = POS_DATA + 2 * DATA_WORDS;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_FORMAT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_LIMIT     = 1'd1;

    localparam logic [7:0] EXPECTED_FORMAT_RST = 8'hff;
    localparam logic [7:0] TRACK_LIMIT_RST     = 8'd164;

    // per-item results of the sector tracker, handed to the output pipeline
    typedef struct packed {
        logic              mem_we;
        logic              mem_re;
        logic [ADDR_W-1:0] mem_addr;
        logic [HALF_W-1:0] half;      // squeezed data bits of this word
        logic              last;
        logic [7:0]        format_byte;
        logic [7:0]        track;
        logic [7:0]        sector_number;
        logic              header_ok;
        logic              data_ok;
        logic              keep;
        logic [6:0]        highest_cylinder;
        logic [7:0]        highest_sector;
    } item_t;

    // gather bits 0,2,..,30 into 16 bits
    function automatic logic [HALF_W-1:0] squeeze(input logic [31:0] w);
        logic [HALF_W-1:0] r;
        for (int i = 0; i < HALF_W; i++)
        begin
            r[i] = w[2*i];
        end
        return r;
    endfunction

    // place bit i at bit 2i
    function automatic logic [31:0] widen(input logic [HALF_W-1:0] h);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < HALF_W; i++)
        begin
            r[2*i] = h[i];
        end
        return r;
    endfunction

endpackage

// ----- hdl/mfmsd_ram.sv -----
module mfmsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/mfmsd_track.sv -----
// Sector position tracking, info/checksum capture, XOR checksums, maxima.
module mfmsd_track (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [31:0]          raw_word,
    input  logic                 sector_start,
    input  logic [7:0]           expected_format,
    input  logic [7:0]           track_limit,
    output mfmsd_pkg::item_t     item
);

    localparam int CW = mfmsd_pkg::CNT_W;
    localparam int AW = mfmsd_pkg::ADDR_W;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [31:0]   info_reg, info_next;
    logic [31:0]   hxor_reg, hxor_next;
    logic [31:0]   dxor_reg, dxor_next;
    logic [31:0]   hck_reg, hck_next;
    logic [31:0]   dck_reg, dck_next;
    logic [6:0]    max_cyl_reg, max_cyl_next;
    logic [7:0]    max_sec_reg, max_sec_next;

    logic [CW-1:0] pos;
    logic [CW-1:0] k;
    logic [31:0]   bits;
    logic          live;
    logic          in_hdr;
    logic          in_data;
    logic          is_read;
    logic          is_last;
    logic [7:0]    fmt, trk, sec;
    logic          hok, dok, kp;

    always_comb
    begin
        pos     = sector_start ? '0 : cnt_reg;
        bits    = raw_word & mfmsd_pkg::MFM_MASK;
        live    = pos < CW'(mfmsd_pkg::SECTOR_WORDS);
        in_hdr  = (pos >= CW'(mfmsd_pkg::POS_INFO_ODD)) && (pos <= CW'(mfmsd_pkg::POS_HDR_LAST));
        in_data = (pos >= CW'(mfmsd_pkg::POS_DATA)) && (pos < CW'(mfmsd_pkg::POS_DATA_END));
        k       = pos - CW'(mfmsd_pkg::POS_DATA);
        is_read = in_data && k[AW];
        is_last = is_read && (&k[AW-1:0]);

        hxor_next = sector_start ? '0 : hxor_reg;
        dxor_next = sector_start ? '0 : dxor_reg;
        if (in_hdr)
        begin
            hxor_next = hxor_next ^ raw_word;
        end
        if (in_data)
        begin
            dxor_next = dxor_next ^ raw_word;
        end

        info_next = info_reg;
        hck_next  = hck_reg;
        dck_next  = dck_reg;
        if (pos == CW'(mfmsd_pkg::POS_INFO_ODD))
        begin
            info_next = {bits[30:0], 1'b0};
        end
        if (pos == CW'(mfmsd_pkg::POS_INFO_EVEN))
        begin
            info_next = info_reg | bits;
        end
        if (pos == CW'(mfmsd_pkg::POS_HCK_ODD))
        begin
            hck_next = {bits[30:0], 1'b0};
        end
        if (pos == CW'(mfmsd_pkg::POS_HCK_EVEN))
        begin
            hck_next = hck_reg | bits;
        end
        if (pos == CW'(mfmsd_pkg::POS_DCK_ODD))
        begin
            dck_next = {bits[30:0], 1'b0};
        end
        if (pos == CW'(mfmsd_pkg::POS_DCK_EVEN))
        begin
            dck_next = dck_reg | bits;
        end

        cnt_next = live ? pos + CW'(1) : cnt_reg;

        fmt = info_reg[31:24];
        trk = info_reg[23:16];
        sec = info_reg[15:8];
        hok = (hxor_next & mfmsd_pkg::MFM_MASK) == hck_reg;
        dok = (dxor_next & mfmsd_pkg::MFM_MASK) == dck_reg;
        kp  = (fmt == expected_format) && (trk < track_limit) && hok;

        max_cyl_next = max_cyl_reg;
        max_sec_next = max_sec_reg;
        if (is_last && kp)
        begin
            if (trk[7:1] > max_cyl_reg)
            begin
                max_cyl_next = trk[7:1];
            end
            if (sec > max_sec_reg)
            begin
                max_sec_next = sec;
            end
        end

        item.mem_we           = in_data && !k[AW];
        item.mem_re           = is_read;
        item.mem_addr         = k[AW-1:0];
        item.half             = mfmsd_pkg::squeeze(raw_word);
        item.last             = is_last;
        item.format_byte      = is_last ? fmt : '0;
        item.track            = is_last ? trk : '0;
        item.sector_number    = is_last ? sec : '0;
        item.header_ok        = is_last && hok;
        item.data_ok          = is_last && dok;
        item.keep             = is_last && kp;
        item.highest_cylinder = is_last ? max_cyl_next : '0;
        item.highest_sector   = is_last ? max_sec_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            info_reg    <= '0;
            hxor_reg    <= '0;
            dxor_reg    <= '0;
            hck_reg     <= '0;
            dck_reg     <= '0;
            max_cyl_reg <= '0;
            max_sec_reg <= '0;
        end
        else if (accept && live)
        begin
            cnt_reg     <= cnt_next;
            info_reg    <= info_next;
            hxor_reg    <= hxor_next;
            dxor_reg    <= dxor_next;
            hck_reg     <= hck_next;
            dck_reg     <= dck_next;
            max_cyl_reg <= max_cyl_next;
            max_sec_reg <= max_sec_next;
        end
        else if (accept && sector_start)
        begin
            // start flag always lands at position 0, so this arm is only
            // reached if SECTOR_WORDS were zero; keep accumulators cleared
            cnt_reg  <= '0;
            hxor_reg <= '0;
            dxor_reg <= '0;
        end
    end

endmodule

// ----- hdl/mfm_odd_even_sector_decoder.sv -----
// MFM odd/even sector decoder.
// Input stream (s_axis_*): one raw MFM longword per item, starting with the
// word after sync; tuser marks word 0 of a new sector. Words 1..2 give the
// info word, 11..14 the header and data checksums, 15..142 the odd data
// halves (kept in a 128 x 16 RAM) and 143..270 the even halves.
// Output stream (m_axis_*): one item per even half, the woven data longword
// with its index; tlast on data word 127, which also carries the info
// fields, both checksum results, the keep flag and the running maxima over
// kept sectors. Summary fields read zero on other items. Words past 270 and
// beyond the sector length are dropped until the next start flag.
// Throughput: one item per cycle while the output is not stalled; each data
// word takes one RAM access (write of an odd half or read of its partner).
// Path: an accepted even half is registered in the RAM-read stage and then
// in the output register, which drives output tvalid.
// Backpressure: the output register and the RAM-read stage stall together;
// s_axis_tready drops only when both hold an item the receiver has not taken.
// Reset clears the counters, accumulators and maxima and loads the
// configuration defaults (format 0xff, track limit 164); the RAM needs no
// clearing since every odd half is written before its even partner reads it.
// Configuration (cfg_*) is always ready and is meant to be written while idle.
module mfm_odd_even_sector_decoder (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mfmsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                       cfg_data,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [39:0]                      s_axis_tdata,  // raw_word[31:0], revolution[39:32]
    input  logic                             s_axis_tuser,  // sector_start
    // output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // data_word[31:0], word_index[38:32], format_byte[46:39], track[54:47],
    // sector_number[62:55], header_ok[63], data_ok[64], keep[65],
    // highest_cylinder[72:66], highest_sector[80:73], revolution_out[88:81],
    // zero fill [95:89]
    output logic [95:0]                      m_axis_tdata,
    output logic                             m_axis_tlast   // last
);

    localparam int AW = mfmsd_pkg::ADDR_W;
    localparam int HW = mfmsd_pkg::HALF_W;

    logic [7:0] exp_fmt_reg;
    logic [7:0] trk_lim_reg;

    logic              accept;
    logic              out_free;
    logic              s1_move;
    mfmsd_pkg::item_t  item;
    logic [HW-1:0]     odd_half;

    // RAM-read stage
    logic              s1_valid_reg, s1_valid_next;
    mfmsd_pkg::item_t  s1_item_reg;
    logic [7:0]        s1_rev_reg;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [95:0]       m_data_reg;
    logic              m_last_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_fmt_reg <= mfmsd_pkg::EXPECTED_FORMAT_RST;
            trk_lim_reg <= mfmsd_pkg::TRACK_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mfmsd_pkg::CFG_EXPECTED_FORMAT: exp_fmt_reg <= cfg_data;
                mfmsd_pkg::CFG_TRACK_LIMIT:     trk_lim_reg <= cfg_data;
                default:                        ;
            endcase
        end
    end

    // handshake: stage 1 moves when the output register frees up
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s1_move       = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    mfmsd_track u_track (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .raw_word        (s_axis_tdata[31:0]),
        .sector_start    (s_axis_tuser),
        .expected_format (exp_fmt_reg),
        .track_limit     (trk_lim_reg),
        .item            (item)
    );

    // odd halves; read data holds while stage 1 stalls since no read is
    // issued without an accept
    mfmsd_ram #(
        .WIDTH (HW),
        .DEPTH (mfmsd_pkg::DATA_WORDS)
    ) u_odd_ram (
        .clk   (clk),
        .we    (accept && item.mem_we),
        .waddr (item.mem_addr),
        .wdata (item.half),
        .re    (accept && item.mem_re),
        .raddr (item.mem_addr),
        .rdata (odd_half)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        if (accept && item.mem_re)
        begin
            s1_valid_next = 1'b1;
        end

        m_valid_next = m_valid_reg;
        if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (s1_move)
        begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && item.mem_re)
        begin
            s1_item_reg <= item;
            s1_rev_reg  <= s_axis_tdata[39:32];
        end
        if (s1_move)
        begin
            // odd bits at odd positions, even bits at even positions
            m_data_reg <= {
                7'd0,
                s1_rev_reg,
                s1_item_reg.highest_sector,
                s1_item_reg.highest_cylinder,
                s1_item_reg.keep,
                s1_item_reg.data_ok,
                s1_item_reg.header_ok,
                s1_item_reg.sector_number,
                s1_item_reg.track,
                s1_item_reg.format_byte,
                s1_item_reg.mem_addr,
                (mfmsd_pkg::widen(odd_half) << 1) | mfmsd_pkg::widen(s1_item_reg.half)
            };
            m_last_reg <= s1_item_reg.last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

// ----- dv/mfmsd_sector_checker.sv -----
module mfmsd_sector_checker
    import mfmsd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [39:0]          s_axis_tdata,  // raw_word[31:0], revolution[39:32]
    input  logic                 s_axis_tuser,  // sector_start
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // data_word, word_index, format_byte, track, sector_number, header_ok,
    // data_ok, keep, highest_cylinder, highest_sector, revolution_out
    input  logic [95:0]          m_axis_tdata,
    input  logic                 m_axis_tlast,  // last
    output int                   mismatches,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] data_word;
        logic [6:0]  word_index;
        logic        last;
        logic [7:0]  format_byte;
        logic [7:0]  track;
        logic [7:0]  sector_number;
        logic        header_ok;
        logic        data_ok;
        logic        keep;
        logic [6:0]  highest_cylinder;
        logic [7:0]  highest_sector;
        logic [7:0]  revolution_out;
    } sector_word_t;

    // sector tracking state of the decoder as predicted here
    logic [CNT_W-1:0] word_pos;
    logic [31:0]      info_q;
    logic [31:0]      hdr_xor;
    logic [31:0]      dat_xor;
    logic [31:0]      hdr_sum;
    logic [31:0]      dat_sum;
    logic [15:0]      odd_halves [DATA_WORDS];
    logic [6:0]       top_cyl;
    logic [7:0]       top_sec;
    logic [7:0]       want_format;
    logic [7:0]       track_ceiling;

    sector_word_t     data_words_q [$];

    // data bits sit at even positions; collect them, bit 30 ends up on top
    function automatic logic [15:0] gather_data_bits(input logic [31:0] raw);
        logic [15:0] r;
        r = '0;
        for (int j = 15; j >= 0; j--)
        begin
            r = {r[14:0], raw[2*j]};
        end
        return r;
    endfunction

    // stored odd half goes to the odd positions, this word's bits to the even
    function automatic logic [31:0] weave(input logic [15:0] odd, input logic [31:0] raw);
        logic [31:0] r;
        r = raw & MFM_MASK;
        for (int j = 0; j < 16; j++)
        begin
            r[2*j+1] = odd[j];
        end
        return r;
    endfunction

    task automatic decode_raw_word(input logic [31:0] raw, input logic start,
                                   input logic [7:0] rev);
        logic [31:0]  bits;
        int           p;
        int           k;
        logic [6:0]   idx;
        sector_word_t e;
        begin
            bits = raw & MFM_MASK;
            if (start)
            begin
                word_pos = '0;
                hdr_xor  = '0;
                dat_xor  = '0;
            end
            p = int'(word_pos);
            if (p < SECTOR_WORDS)
            begin
                word_pos = word_pos + 1'b1;
                if (p >= POS_INFO_ODD && p <= POS_HDR_LAST)
                    hdr_xor ^= raw;
                if (p == POS_INFO_ODD)
                    info_q = bits << 1;
                else if (p == POS_INFO_EVEN)
                    info_q |= bits;
                else if (p == POS_HCK_ODD)
                    hdr_sum = bits << 1;
                else if (p == POS_HCK_EVEN)
                    hdr_sum |= bits;
                else if (p == POS_DCK_ODD)
                    dat_sum = bits << 1;
                else if (p == POS_DCK_EVEN)
                    dat_sum |= bits;
                else if (p >= POS_DATA && p < POS_DATA_END)
                begin
                    k = p - POS_DATA;
                    dat_xor ^= raw;
                    if (k < DATA_WORDS)
                        odd_halves[k] = gather_data_bits(raw);
                    else
                    begin
                        idx              = 7'(k - DATA_WORDS);
                        e                = '0;
                        e.data_word      = weave(odd_halves[idx], raw);
                        e.word_index     = idx;
                        e.last           = (k - DATA_WORDS == DATA_WORDS - 1);
                        e.revolution_out = rev;
                        if (e.last)
                        begin
                            e.format_byte   = info_q[31:24];
                            e.track         = info_q[23:16];
                            e.sector_number = info_q[15:8];
                            e.header_ok     = ((hdr_xor & MFM_MASK) == hdr_sum);
                            e.data_ok       = ((dat_xor & MFM_MASK) == dat_sum);
                            e.keep          = (e.format_byte == want_format) &&
                                              (e.track < track_ceiling) && e.header_ok;
                            if (e.keep)
                            begin
                                if (e.track[7:1] > top_cyl)
                                    top_cyl = e.track[7:1];
                                if (e.sector_number > top_sec)
                                    top_sec = e.sector_number;
                            end
                            e.highest_cylinder = top_cyl;
                            e.highest_sector   = top_sec;
                        end
                        data_words_q.push_back(e);
                    end
                end
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_data_word();
        sector_word_t e;
        begin
            if (data_words_q.size() == 0)
            begin
                $error("data word out with none pending: %h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                e = data_words_q.pop_front();
                compare_field("data_word",        e.data_word,        m_axis_tdata[31:0]);
                compare_field("word_index",       e.word_index,       m_axis_tdata[38:32]);
                compare_field("last",             e.last,             m_axis_tlast);
                compare_field("format_byte",      e.format_byte,      m_axis_tdata[46:39]);
                compare_field("track",            e.track,            m_axis_tdata[54:47]);
                compare_field("sector_number",    e.sector_number,    m_axis_tdata[62:55]);
                compare_field("header_ok",        e.header_ok,        m_axis_tdata[63]);
                compare_field("data_ok",          e.data_ok,          m_axis_tdata[64]);
                compare_field("keep",             e.keep,             m_axis_tdata[65]);
                compare_field("highest_cylinder", e.highest_cylinder, m_axis_tdata[72:66]);
                compare_field("highest_sector",   e.highest_sector,   m_axis_tdata[80:73]);
                compare_field("revolution_out",   e.revolution_out,   m_axis_tdata[88:81]);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_pos      = '0;
            info_q        = '0;
            hdr_xor       = '0;
            dat_xor       = '0;
            hdr_sum       = '0;
            dat_sum       = '0;
            top_cyl       = '0;
            top_sec       = '0;
            want_format   = EXPECTED_FORMAT_RST;
            track_ceiling = TRACK_LIMIT_RST;
            mismatches    = 0;
            data_words_q.delete();
            pending <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_data_word();
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_EXPECTED_FORMAT: want_format   = cfg_data;
                    CFG_TRACK_LIMIT:     track_ceiling = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                decode_raw_word(s_axis_tdata[31:0], s_axis_tuser, s_axis_tdata[39:32]);
            pending <= data_words_q.size();
        end
    end

endmodule

// ----- dv/tb.sv -----
// Stimulus and verdict for the MFM odd/even sector decoder. The checker
// beside the block watches every channel and counts mismatches; this module
// only drives the channels and decides pass/fail.
module tb;
    import mfmsd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAIL_WORDS   = 5;   // words past the trailing one, hit saturation
    localparam int DRAIN_CYCLES = 8;   // margin past the RAM-read stage and output register

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [39:0]          s_axis_tdata;   // raw_word[31:0], revolution[39:32]
    logic                 s_axis_tuser;   // sector_start
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // data_word, word_index, format_byte, track, sector_number, header_ok,
    // data_ok, keep, highest_cylinder, highest_sector, revolution_out
    logic [95:0]          m_axis_tdata;
    logic                 m_axis_tlast;   // last

    int                   mismatches;
    int                   pending;

    // current register values, so sectors can aim at the keep decision
    logic [7:0]           cur_format;
    logic [7:0]           cur_limit;
    // when set, neither side idles
    bit                   steady_flow;
    int                   rx_hold = 0;

    // one sector image: word 0 (after sync) up to a few words past the end
    logic [31:0]          sec_words [SECTOR_WORDS + TAIL_WORDS];

    always #5 clk = ~clk;

    mfm_odd_even_sector_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    mfmsd_sector_checker u_sector_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    // idle stretch length from three ranges, short ones most often, long ones rarely
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // data bits placed, clock bit positions filled at random
    function automatic logic [31:0] with_clock_bits(input logic [31:0] bits);
        return (bits & MFM_MASK) | ($urandom() & ~MFM_MASK);
    endfunction

    // receiver: runs of ready broken by idle stretches
    always @(negedge clk)
    begin
        if (rx_hold > 0)
            rx_hold = rx_hold - 1;
        else if (steady_flow || $urandom_range(0, 99) < 65)
        begin
            m_axis_tready <= 1'b1;
            rx_hold = $urandom_range(0, 12);
        end
        else
        begin
            m_axis_tready <= 1'b0;
            rx_hold = idle_length() - 1;
        end
    end

    // present one item at a falling edge, return at the accepting rising edge;
    // tvalid stays high across back-to-back items
    task automatic send_item(input logic [31:0] raw, input logic start,
                             input logic [7:0] rev);
        int gap;
        begin
            gap = (steady_flow || $urandom_range(0, 99) < 60) ? 0 : idle_length();
            @(negedge clk);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {rev, raw};
            s_axis_tuser  <= start;
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stop sending, wait for every data word, then let non-result items drain
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Build one sector with a chosen info word and matching (or, now and
    // then, corrupted) checksums, then send its first n_words words.
    // n_words below 271 gives a sector cut short; above it, trailing words
    // and words past the saturated count.
    task automatic send_sector(input int n_words);
        logic [31:0] r;
        logic [31:0] info;
        logic [31:0] hsum;
        logic [31:0] dsum;
        logic [7:0]  fmt;
        logic [7:0]  trk;
        logic [7:0]  secn;
        int          fill;
        begin
            r    = $urandom();
            fmt  = ($urandom_range(0, 3) == 0) ? r[7:0] : cur_format;
            case ($urandom_range(0, 7))
                0:       trk = 8'd0;
                1:       trk = 8'hff;
                2:       trk = 8'hfe;
                3:       trk = cur_limit - 8'd1;
                4:       trk = cur_limit;
                default: trk = r[15:8];
            endcase
            secn = (r[25:24] == 2'd0) ? 8'hff : r[23:16];
            info = {fmt, trk, secn, r[31:26], r[1:0]};

            sec_words[0] = $urandom();
            sec_words[POS_INFO_ODD]  = with_clock_bits(info >> 1);
            sec_words[POS_INFO_EVEN] = with_clock_bits(info);
            for (int p = POS_INFO_EVEN + 1; p <= POS_HDR_LAST; p++)
                sec_words[p] = $urandom();

            hsum = '0;
            for (int p = POS_INFO_ODD; p <= POS_HDR_LAST; p++)
                hsum ^= sec_words[p];
            hsum &= MFM_MASK;
            if ($urandom_range(0, 3) == 0)
                hsum ^= 32'h1 << (2 * $urandom_range(0, 15));
            sec_words[POS_HCK_ODD]  = with_clock_bits(hsum >> 1);
            sec_words[POS_HCK_EVEN] = with_clock_bits(hsum);

            // data content: random, all zero, all ones, or alternating bits
            fill = $urandom_range(0, 4);
            for (int p = POS_DATA; p < POS_DATA_END; p++)
            begin
                case (fill)
                    1:       sec_words[p] = 32'h0000_0000;
                    2:       sec_words[p] = 32'hffff_ffff;
                    3:       sec_words[p] = p[0] ? 32'haaaa_aaaa : 32'h5555_5555;
                    default: sec_words[p] = $urandom();
                endcase
            end

            dsum = '0;
            for (int p = POS_DATA; p < POS_DATA_END; p++)
                dsum ^= sec_words[p];
            dsum &= MFM_MASK;
            if ($urandom_range(0, 3) == 0)
                dsum ^= 32'h1 << (2 * $urandom_range(0, 15));
            sec_words[POS_DCK_ODD]  = with_clock_bits(dsum >> 1);
            sec_words[POS_DCK_EVEN] = with_clock_bits(dsum);

            for (int p = POS_DATA_END; p < SECTOR_WORDS + TAIL_WORDS; p++)
                sec_words[p] = $urandom();

            for (int p = 0; p < n_words; p++)
                send_item(sec_words[p], (p == 0), 8'($urandom_range(0, 255)));
        end
    endtask

    // runaway guard
    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_EXPECTED_FORMAT;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cur_format    = EXPECTED_FORMAT_RST;
        cur_limit     = TRACK_LIMIT_RST;
        steady_flow   = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: words with no start flag right after reset continue the
        // count from zero; extremes of raw word and revolution.
        send_item(32'hffff_ffff, 1'b0, 8'hff);
        send_item(32'h0000_0000, 1'b0, 8'h00);
        send_item(32'haaaa_aaaa, 1'b0, 8'h80);
        send_item(32'h5555_5555, 1'b0, 8'h01);
        // start flag in mid-count, then twice in a row
        send_item($urandom(), 1'b1, 8'h7f);
        send_item($urandom(), 1'b0, 8'hfe);
        send_item($urandom(), 1'b1, 8'h55);
        send_item($urandom(), 1'b1, 8'haa);
        // header and checksum words only, cut before the data region
        for (int i = 0; i < 14; i++)
            send_item($urandom(), 1'b0, 8'($urandom_range(0, 255)));

        // Phases: reset defaults, all-low extremes, all-high extremes, random.
        // Complete sectors go out in the reset-default and all-high phases.
        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase > 0)
            begin
                settle();
                case (phase)
                    1:
                    begin
                        cur_format = 8'h00;
                        cur_limit  = 8'h00;
                    end
                    2:
                    begin
                        cur_format = 8'hff;
                        cur_limit  = 8'hff;
                    end
                    default:
                    begin
                        cur_format = 8'($urandom_range(0, 255));
                        cur_limit  = 8'($urandom_range(0, 255));
                    end
                endcase
                if ($urandom_range(0, 1) == 0)
                begin
                    write_reg(CFG_EXPECTED_FORMAT, cur_format);
                    write_reg(CFG_TRACK_LIMIT, cur_limit);
                end
                else
                begin
                    write_reg(CFG_TRACK_LIMIT, cur_limit);
                    write_reg(CFG_EXPECTED_FORMAT, cur_format);
                end
            end
            // one phase runs without any idling on either side
            steady_flow = (phase == 2);

            if (phase == 0 || phase == 2)
                send_sector(POS_DATA_END + $urandom_range(0, TAIL_WORDS + 1));
            // noise: random words, start flag on about a quarter of them
            repeat ($urandom_range(1, 12))
                send_item($urandom(), ($urandom_range(0, 3) == 0),
                          8'($urandom_range(0, 255)));
            // a sector broken off early, at most 15 odd halves in
            send_sector($urandom_range(1, 2 * POS_DATA));
        end

        settle();
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
